// ===== rtl/core/sqd_pkg.sv =====
// Shared types, constants and helpers for the shortest queue dispatcher.
package sqd_pkg;

  // Parameter defaults
  localparam int LANE_COUNT_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 16;

  // Lanes that can hold work: only lanes with an active mask bit receive arrivals
  localparam int MAX_TREE_LANES = 16;

  // Field widths
  localparam int LANE_W      = 4;
  localparam int STATUS_W    = 3;
  localparam int OUT_LEN_W   = 16;
  localparam int TOTAL_W     = 32;
  localparam int CFG_LANES_W = 5;
  localparam int CFG_CAP_W   = 16;
  localparam int MASK_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 120;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LANES_IN_USE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK    = 2'd2;

  // Register reset values
  localparam logic [CFG_LANES_W-1:0] LANES_IN_USE_RST   = 5'd16;
  localparam logic [CFG_CAP_W-1:0]   QUEUE_CAPACITY_RST = 16'd0;
  localparam logic [MASK_W-1:0]      ACTIVE_MASK_RST    = 16'hFFFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BALKED    = 3'd1,
    ST_NO_LANE   = 3'd2,
    ST_INVALID   = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;    // capture the input beat
    logic commit;  // apply the event and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_depart;  // mode of the beat on the input channel
    logic out_stall;  // result register full and not being taken
  } dp_status_t;

  // Levels of the registered minimum tree for a given lane count
  function automatic int tree_levels(int lane_count);
    int nl;
    nl = (lane_count < MAX_TREE_LANES) ? lane_count : MAX_TREE_LANES;
    return (nl > 1) ? $clog2(nl) : 1;
  endfunction

endpackage

// ===== rtl/core/sqd_ctrl.sv =====
// Controller state machine: sequences capture, tree settle and commit of one event; departures skip the tree settle.
module sqd_ctrl #(
  parameter int LANE_COUNT = sqd_pkg::LANE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  sqd_pkg::dp_status_t    status,
  output sqd_pkg::ctrl_cmd_t     cmd
);
  import sqd_pkg::*;

  localparam int LEVELS = tree_levels(LANE_COUNT);
  localparam int CNT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (s_tvalid) begin
          // departures need no minimum search
          state_next = status.in_depart ? S_COMMIT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(LEVELS - 1)) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!status.out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_SEARCH: ;
      S_COMMIT: begin
        cmd.commit = !status.out_stall;
      end
      default: ;
    endcase
  end

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_SEARCH || state == S_COMMIT))
    else $error("load did not start an event");

  a_search_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (cnt <= CNT_W'(LEVELS - 1)))
    else $error("search ran past the tree depth");

endmodule

// ===== rtl/core/sqd_dpath.sv =====
// Datapath: lane counts, config registers, registered minimum tree and result register.
module sqd_dpath #(
  parameter int LANE_COUNT  = sqd_pkg::LANE_COUNT_DEF,
  parameter int LENGTH_BITS = sqd_pkg::LENGTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sqd_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sqd_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [sqd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sqd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  sqd_pkg::ctrl_cmd_t                  cmd,
  output sqd_pkg::dp_status_t                 status
);
  import sqd_pkg::*;

  localparam int NL        = (LANE_COUNT < MAX_TREE_LANES) ? LANE_COUNT : MAX_TREE_LANES;
  localparam int LEVELS    = tree_levels(LANE_COUNT);
  localparam int TREE_SIZE = 1 << LEVELS;
  localparam int CMP_W     = (LENGTH_BITS > CFG_CAP_W) ? LENGTH_BITS : CFG_CAP_W;
  localparam int LIM_W     = 7;

  function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Config registers
  logic [CFG_LANES_W-1:0] lanes_in_use;
  logic [CFG_CAP_W-1:0]   queue_capacity;
  logic [MASK_W-1:0]      active_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes_in_use   <= LANES_IN_USE_RST;
      queue_capacity <= QUEUE_CAPACITY_RST;
      active_mask    <= ACTIVE_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LANES_IN_USE:   lanes_in_use   <= cfg_wdata[CFG_LANES_W-1:0];
        CFG_QUEUE_CAPACITY: queue_capacity <= cfg_wdata[CFG_CAP_W-1:0];
        CFG_ACTIVE_MASK:    active_mask    <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured event
  logic              depart_q;
  logic [LANE_W-1:0] lane_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      depart_q <= s_tuser;
      lane_q   <= s_tdata[LANE_W-1:0];
    end
  end

  // Lane counts and totals
  logic [LENGTH_BITS-1:0] len_q [NL];
  logic [TOTAL_W-1:0]     arr_cnt, srv_cnt, blk_cnt;

  // Minimum tree: leaves from the counts, one registered level per cycle
  logic                   leaf_vld [TREE_SIZE];
  logic [LANE_W-1:0]      leaf_idx [TREE_SIZE];
  logic [LENGTH_BITS-1:0] leaf_len [TREE_SIZE];
  logic                   node_vld [1:TREE_SIZE-1];
  logic [LANE_W-1:0]      node_idx [1:TREE_SIZE-1];
  logic [LENGTH_BITS-1:0] node_len [1:TREE_SIZE-1];

  for (genvar i = 0; i < TREE_SIZE; i++) begin : g_leaf
    if (i < NL) begin : g_used
      assign leaf_vld[i] = (CFG_LANES_W'(i) < lanes_in_use) && active_mask[i];
      assign leaf_idx[i] = LANE_W'(i);
      assign leaf_len[i] = len_q[i];
    end else begin : g_pad
      assign leaf_vld[i] = 1'b0;
      assign leaf_idx[i] = '0;
      assign leaf_len[i] = '0;
    end
  end

  for (genvar n = 1; n < TREE_SIZE; n++) begin : g_node
    logic                   l_vld, r_vld;
    logic [LANE_W-1:0]      l_idx, r_idx;
    logic [LENGTH_BITS-1:0] l_len, r_len;
    if (2 * n >= TREE_SIZE) begin : g_from_leaf
      assign l_vld = leaf_vld[2*n-TREE_SIZE];
      assign l_idx = leaf_idx[2*n-TREE_SIZE];
      assign l_len = leaf_len[2*n-TREE_SIZE];
      assign r_vld = leaf_vld[2*n+1-TREE_SIZE];
      assign r_idx = leaf_idx[2*n+1-TREE_SIZE];
      assign r_len = leaf_len[2*n+1-TREE_SIZE];
    end else begin : g_from_node
      assign l_vld = node_vld[2*n];
      assign l_idx = node_idx[2*n];
      assign l_len = node_len[2*n];
      assign r_vld = node_vld[2*n+1];
      assign r_idx = node_idx[2*n+1];
      assign r_len = node_len[2*n+1];
    end
    // ties go left, which keeps the lower lane number
    always_ff @(posedge clk) begin
      if (l_vld && (!r_vld || l_len <= r_len)) begin
        node_vld[n] <= 1'b1;
        node_idx[n] <= l_idx;
        node_len[n] <= l_len;
      end else begin
        node_vld[n] <= r_vld;
        node_idx[n] <= r_idx;
        node_len[n] <= r_len;
      end
    end
  end

  // Departure lane read
  logic [LENGTH_BITS-1:0] rd_len;

  always_comb begin
    rd_len = '0;
    for (int i = 0; i < NL; i++) begin
      if (lane_q == LANE_W'(i)) rd_len = len_q[i];
    end
  end

  // Event resolution
  logic                   lane_ok;
  logic                   full;
  logic [CMP_W-1:0]       cur_ext;
  logic                   len_we;
  logic [LANE_W-1:0]      wr_idx;
  logic [LENGTH_BITS-1:0] wr_len;
  logic [LANE_W-1:0]      res_lane;
  status_t                res_status;
  logic                   res_start;
  logic [CMP_W-1:0]       res_len;
  logic [TOTAL_W-1:0]     arr_next, srv_next, blk_next;

  assign lane_ok = ({1'b0, lane_q} < lanes_in_use) &&
                   ({3'b000, lane_q} < LIM_W'(LANE_COUNT));
  assign cur_ext = depart_q ? CMP_W'(rd_len) : CMP_W'(node_len[1]);
  assign full    = ((queue_capacity != '0) && (cur_ext >= CMP_W'(queue_capacity))) ||
                   (&node_len[1]);

  always_comb begin
    len_we     = 1'b0;
    wr_idx     = '0;
    wr_len     = '0;
    res_lane   = '0;
    res_status = ST_OK;
    res_start  = 1'b0;
    res_len    = '0;
    arr_next   = arr_cnt;
    srv_next   = srv_cnt;
    blk_next   = blk_cnt;
    if (!depart_q) begin
      arr_next = sat_inc(arr_cnt);
      if (!node_vld[1]) begin
        res_status = ST_NO_LANE;
      end else begin
        res_lane = node_idx[1];
        if (full) begin
          res_status = ST_BALKED;
          res_len    = cur_ext;
          blk_next   = sat_inc(blk_cnt);
        end else begin
          len_we    = 1'b1;
          wr_idx    = node_idx[1];
          wr_len    = node_len[1] + 1'b1;
          res_len   = CMP_W'(wr_len);
          res_start = (node_len[1] == '0);
        end
      end
    end else begin
      res_lane = lane_q;
      if (!lane_ok) begin
        res_status = ST_INVALID;
      end else if (rd_len == '0) begin
        res_status = ST_UNDERFLOW;
      end else begin
        len_we    = 1'b1;
        wr_idx    = lane_q;
        wr_len    = rd_len - 1'b1;
        res_len   = CMP_W'(wr_len);
        res_start = (wr_len != '0);
        srv_next  = sat_inc(srv_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NL; i++) len_q[i] <= '0;
      arr_cnt <= '0;
      srv_cnt <= '0;
      blk_cnt <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < NL; i++) begin
        if (len_we && wr_idx == LANE_W'(i)) len_q[i] <= wr_len;
      end
      arr_cnt <= arr_next;
      srv_cnt <= srv_next;
      blk_cnt <= blk_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {blk_next, srv_next, arr_next, res_len[OUT_LEN_W-1:0],
                  res_start, res_status, res_lane};
    end
  end

  assign status.in_depart = s_tuser;
  assign status.out_stall = m_tvalid && !m_tready;

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready))
    else $error("commit overwrote a pending result");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  a_arrivals_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> arr_cnt >= $past(arr_cnt))
    else $error("arrival total went down");

endmodule

// ===== rtl/core/shortest_queue_dispatcher_top.sv =====
// Top level of the join-shortest-queue dispatcher.
//
// Input channel s_*: one beat per event. s_tuser is the event kind (0 arrival,
// 1 departure), s_tdata[3:0] the departing lane. Output channel m_*: one beat
// per event with the chosen lane, status, start flag, new queue length and the
// three saturating totals. Config port: cfg_we writes cfg_wdata into register
// cfg_index (0 lanes in use, 1 queue capacity, 2 active mask) at the clock edge.
//
// An arrival waits for the registered minimum tree over the lane counts to
// settle, one tree level per cycle: clog2(min(LANE_COUNT,16)) levels (at least
// one); the controller steps through its idle (capture), search and commit states,
// and a new input beat is taken only once the previous event has committed.
// A departure reads its lane directly and skips the search state.
//
// Reset (rst, synchronous) clears all lane counts and totals and restores the
// register defaults. The result register holds one beat; while it waits for
// m_tready the next event is still accepted and worked up to its commit,
// which then holds until the result register is free.
module shortest_queue_dispatcher_top #(
  parameter int LANE_COUNT  = sqd_pkg::LANE_COUNT_DEF,
  parameter int LENGTH_BITS = sqd_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sqd_pkg::IN_TDATA_W-1:0]   s_tdata,   // lane_in[3:0], zero pad
  input  logic                             s_tuser,   // mode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // lane_out[3:0], status[6:4], start_service[7], new_length[23:8],
  // arrivals_total[55:24], served_total[87:56], balked_total[119:88]
  output logic [sqd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [sqd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sqd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sqd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sqd_ctrl #(
    .LANE_COUNT (LANE_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sqd_dpath #(
    .LANE_COUNT  (LANE_COUNT),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
